FILE: hdl/metric_threshold_alarm_check_defines.svh
// assertion macros for the metric threshold alarm check
// expects clk and rst in the scope of each use
`ifndef METRIC_THRESHOLD_ALARM_CHECK_DEFINES_SVH
`define METRIC_THRESHOLD_ALARM_CHECK_DEFINES_SVH

// same-cycle implication, disabled in reset
`define MTAC_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtac assertion failed");

// next-cycle implication, disabled in reset
`define MTAC_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtac assertion failed");

`endif

FILE: hdl/mtac_pkg.sv
// shared types and constants of the metric threshold alarm check
// no dependencies
`timescale 1ns / 1ps

package mtac_pkg;

  localparam int VAL_W  = 32;
  localparam int MIN_W  = 11;
  localparam int CHG_W  = 31;
  localparam int FLAG_W = 7;
  localparam int OBS_W  = 39;

  // rule flag bit positions
  localparam int FLAG_MIN_EN   = 0;
  localparam int FLAG_MAX_EN   = 1;
  localparam int FLAG_CHG_EN   = 2;
  localparam int FLAG_MASK     = 3;
  localparam int FLAG_EXCEPT   = 4;
  localparam int FLAG_DENY_ALL = 5;
  localparam int FLAG_DENY_EXC = 6;

  typedef enum logic [1:0] {
    KIND_LOW    = 2'd0,
    KIND_HIGH   = 2'd1,
    KIND_CHANGE = 2'd2
  } alarm_kind_t;

  typedef struct packed {
    logic [VAL_W-1:0]  now_seconds;
    logic [MIN_W-1:0]  current_minute;
    logic [VAL_W-1:0]  report_seconds;
    logic [MIN_W-1:0]  record_minute;
    logic [VAL_W-1:0]  current_value;
    logic [VAL_W-1:0]  last_value;
    logic [VAL_W-1:0]  prior_value;
    logic              is_cumulative;
    logic [FLAG_W-1:0] rule_flags;
    logic [VAL_W-1:0]  limit_low;
    logic [VAL_W-1:0]  limit_high;
    logic [CHG_W-1:0]  limit_change;
  } req_t;

  typedef struct packed {
    alarm_kind_t      alarm_kind;
    logic             masked;
    logic [VAL_W-1:0] limit_value;
    logic [OBS_W-1:0] observed_value;
    logic             last_alarm;
  } alarm_t;

  // what one divider cell holds and hands to the next
  typedef struct packed {
    logic [VAL_W-1:0] last;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
    logic [CHG_W-1:0] chg;
    logic             low_hit;
    logic             high_hit;
    logic             chg_en;
    logic             masked;
    logic [VAL_W-1:0] divisor;
    logic [VAL_W-1:0] rem;
    logic [OBS_W-1:0] nq;
  } cell_t;

endpackage

FILE: hdl/mtac_stream_if.sv
// valid/ready channel carrying one payload item
// payload type given as a type parameter, usually from mtac_pkg
`timescale 1ns / 1ps

interface mtac_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

FILE: hdl/mtac_front.sv
// front end: minute reduction, realignment, limit compares, change numerator
// depends on mtac_pkg
`timescale 1ns / 1ps

module mtac_front #(
  parameter int MINUTES_PER_DAY = 1440
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mtac_pkg::req_t in_data,
  output logic           out_valid,
  input  logic           out_take,
  output mtac_pkg::cell_t out_cell
);
  import mtac_pkg::*;

  localparam int RECIP_SHIFT = 24;
  localparam int RECIP       = ((1 << RECIP_SHIFT) + MINUTES_PER_DAY - 1) / MINUTES_PER_DAY;
  localparam int PROD_W      = MIN_W + RECIP_SHIFT;
  localparam logic [RECIP_SHIFT-1:0] RECIP_K   = RECIP_SHIFT'(RECIP);
  localparam logic [MIN_W-1:0]       DAY_MIN   = MIN_W'(MINUTES_PER_DAY);
  localparam logic [MIN_W-1:0]       DAY_LAST  = MIN_W'(MINUTES_PER_DAY - 1);
  localparam logic [VAL_W:0]         STALE_SEC = (VAL_W + 1)'(MINUTES_PER_DAY * 60);

  logic [3:0] v;
  logic [3:0] take;

  // stage 1 regs
  req_t              d1;
  logic [PROD_W-1:0] prod1;
  logic              stale1;
  // stage 2 regs
  req_t              d2;
  logic              stale2;
  logic [MIN_W-1:0]  rmod2;
  // stage 3 regs
  logic [VAL_W-1:0]  last3;
  logic [VAL_W-1:0]  prior3;
  logic [VAL_W-1:0]  lo3;
  logic [VAL_W-1:0]  hi3;
  logic [CHG_W-1:0]  chg3;
  logic [2:0]        en3;
  logic              masked3;

  logic [PROD_W-1:0]  prod_s0;
  logic               stale_s0;
  logic [MIN_W-1:0]   quo_s1;
  logic [2*MIN_W-1:0] qm_s1;
  logic [MIN_W-1:0]   rem_raw_s1;
  logic [MIN_W-1:0]   rem_s1;
  logic [MIN_W-1:0]   min1_s2;
  logic [MIN_W-1:0]   min2_s2;
  logic [VAL_W-1:0]   last_s2;
  logic [VAL_W-1:0]   prior_s2;
  logic               masked_s2;
  logic [VAL_W-1:0]   diff_s3;
  logic [OBS_W-1:0]   diff_w_s3;
  cell_t              cell_s3;

  assign take[3]  = !v[3] || out_take;
  assign take[2]  = !v[2] || take[3];
  assign take[1]  = !v[1] || take[2];
  assign take[0]  = !v[0] || take[1];
  assign in_ready  = take[0];
  assign out_valid = v[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (take[0]) v[0] <= in_valid;
      if (take[1]) v[1] <= v[0];
      if (take[2]) v[2] <= v[1];
      if (take[3]) v[3] <= v[2];
    end
  end

  // stage 1: reciprocal product for minute mod day, stale compare
  assign prod_s0  = PROD_W'(in_data.record_minute) * PROD_W'(RECIP_K);
  assign stale_s0 = {1'b0, in_data.now_seconds} >= ({1'b0, in_data.report_seconds} + STALE_SEC);

  always_ff @(posedge clk) begin
    if (take[0]) begin
      d1     <= in_data;
      prod1  <= prod_s0;
      stale1 <= stale_s0;
    end
  end

  // stage 2: remainder with one correction step
  always_comb begin
    quo_s1     = prod1[RECIP_SHIFT +: MIN_W];
    qm_s1      = (2*MIN_W)'(quo_s1) * (2*MIN_W)'(DAY_MIN);
    rem_raw_s1 = d1.record_minute - qm_s1[MIN_W-1:0];
    rem_s1     = (rem_raw_s1 >= DAY_MIN) ? (rem_raw_s1 - DAY_MIN) : rem_raw_s1;
  end

  always_ff @(posedge clk) begin
    if (take[1]) begin
      d2     <= d1;
      stale2 <= stale1;
      rmod2  <= rem_s1;
    end
  end

  // stage 3: realign stored values to the current minute
  always_comb begin
    min1_s2  = (rmod2 == DAY_LAST) ? '0 : rmod2 + MIN_W'(1);
    min2_s2  = (min1_s2 == DAY_LAST) ? '0 : min1_s2 + MIN_W'(1);
    last_s2  = d2.last_value;
    prior_s2 = d2.prior_value;
    if (d2.is_cumulative) begin
      if (d2.prior_value >= d2.last_value) last_s2 = d2.prior_value;
    end else if (stale2) begin
      last_s2  = '0;
      prior_s2 = '0;
    end else if (d2.current_minute != d2.record_minute) begin
      if (min1_s2 == d2.current_minute) begin
        prior_s2 = d2.last_value;
        last_s2  = d2.current_value;
      end else if (min2_s2 == d2.current_minute) begin
        prior_s2 = d2.current_value;
        last_s2  = '0;
      end else begin
        last_s2  = '0;
        prior_s2 = '0;
      end
    end
    masked_s2 = d2.rule_flags[FLAG_MASK] | d2.rule_flags[FLAG_DENY_ALL] |
                (d2.rule_flags[FLAG_DENY_EXC] & d2.rule_flags[FLAG_EXCEPT]);
  end

  always_ff @(posedge clk) begin
    if (take[2]) begin
      last3   <= last_s2;
      prior3  <= prior_s2;
      lo3     <= d2.limit_low;
      hi3     <= d2.limit_high;
      chg3    <= d2.limit_change;
      en3     <= {d2.rule_flags[FLAG_CHG_EN], d2.rule_flags[FLAG_MAX_EN],
                  d2.rule_flags[FLAG_MIN_EN]};
      masked3 <= masked_s2;
    end
  end

  // stage 4: limit compares and the change numerator |last-prior|*100
  always_comb begin
    diff_s3   = (last3 >= prior3) ? (last3 - prior3) : (prior3 - last3);
    diff_w_s3 = OBS_W'(diff_s3);
    cell_s3.last     = last3;
    cell_s3.lo       = lo3;
    cell_s3.hi       = hi3;
    cell_s3.chg      = chg3;
    cell_s3.low_hit  = en3[0] && (last3 < lo3);
    cell_s3.high_hit = en3[1] && (last3 > hi3);
    cell_s3.chg_en   = en3[2] && (prior3 != '0);
    cell_s3.masked   = masked3;
    cell_s3.divisor  = prior3;
    cell_s3.rem      = '0;
    cell_s3.nq       = (diff_w_s3 << 6) + (diff_w_s3 << 5) + (diff_w_s3 << 2);
  end

  always_ff @(posedge clk) begin
    if (take[3]) out_cell <= cell_s3;
  end

endmodule

FILE: hdl/mtac_div_cell.sv
// one restoring-division cell: one quotient bit per cell, then a register
// depends on mtac_pkg
`timescale 1ns / 1ps

module mtac_div_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_take,
  input  mtac_pkg::cell_t up_cell,
  output logic            dn_valid,
  input  logic            dn_take,
  output mtac_pkg::cell_t dn_cell
);
  import mtac_pkg::*;

  logic           v;
  cell_t          c;
  logic [VAL_W:0] trial;
  logic [VAL_W:0] less;
  logic           fits;
  cell_t          step;

  assign up_take  = !v || dn_take;
  assign dn_valid = v;
  assign dn_cell  = c;

  // shift the next numerator bit into the remainder, subtract if it fits
  always_comb begin
    trial     = {up_cell.rem, up_cell.nq[OBS_W-1]};
    less      = trial - {1'b0, up_cell.divisor};
    fits      = trial >= {1'b0, up_cell.divisor};
    step      = up_cell;
    step.rem  = fits ? less[VAL_W-1:0] : trial[VAL_W-1:0];
    step.nq   = {up_cell.nq[OBS_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_take) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take) c <= step;
  end

endmodule

FILE: hdl/mtac_emit.sv
// output stage: final change compare and one alarm item per firing check
// depends on mtac_pkg
`timescale 1ns / 1ps

module mtac_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_take,
  input  mtac_pkg::cell_t  up_cell,
  output logic             out_valid,
  input  logic             out_ready,
  output mtac_pkg::alarm_t out_data
);
  import mtac_pkg::*;

  logic [2:0]       pend;
  logic [2:0]       low_bit;
  logic             last_one;
  logic             fire;
  logic             hit_chg;
  logic [VAL_W-1:0] last_q;
  logic [VAL_W-1:0] lo_q;
  logic [VAL_W-1:0] hi_q;
  logic [CHG_W-1:0] chg_q;
  logic [OBS_W-1:0] quo_q;
  logic             masked_q;

  assign hit_chg   = up_cell.chg_en && (up_cell.nq > OBS_W'(up_cell.chg));
  assign out_valid = |pend;
  assign fire      = out_valid && out_ready;
  assign low_bit   = pend & (~pend + 3'd1);
  assign last_one  = (pend & (pend - 3'd1)) == 3'd0;
  assign up_take   = !out_valid || (fire && last_one);

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (up_take) begin
      pend <= up_valid ? {hit_chg, up_cell.high_hit, up_cell.low_hit} : 3'd0;
    end else if (fire) begin
      pend <= pend & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (up_take) begin
      last_q   <= up_cell.last;
      lo_q     <= up_cell.lo;
      hi_q     <= up_cell.hi;
      chg_q    <= up_cell.chg;
      quo_q    <= up_cell.nq;
      masked_q <= up_cell.masked;
    end
  end

  // lowest pending check goes out first
  always_comb begin
    out_data.masked     = masked_q;
    out_data.last_alarm = last_one;
    if (pend[0]) begin
      out_data.alarm_kind     = KIND_LOW;
      out_data.limit_value    = lo_q;
      out_data.observed_value = OBS_W'(last_q);
    end else if (pend[1]) begin
      out_data.alarm_kind     = KIND_HIGH;
      out_data.limit_value    = hi_q;
      out_data.observed_value = OBS_W'(last_q);
    end else begin
      out_data.alarm_kind     = KIND_CHANGE;
      out_data.limit_value    = VAL_W'(chg_q);
      out_data.observed_value = quo_q;
    end
  end

endmodule

FILE: hdl/metric_threshold_alarm_check.sv
// top level of the metric threshold alarm check
// depends on mtac_pkg, mtac_stream_if, mtac_front, mtac_div_cell, mtac_emit
`timescale 1ns / 1ps

// One metric record per req item goes in; zero to three alarm items come out, in the order
// below minimum, above maximum, change too large, the final one marked with last_alarm. The
// block keeps no state between records and has no registers to set. Every stage is elastic,
// so a new record is taken in every cycle as long as the alarm side keeps up. An accepted
// record passes four front-end stages, a row of 39 division cells (one quotient bit of
// |last-prior|*100/prior per cell) and the output register before its first alarm. The
// output register sends one alarm per cycle while the alarm side is ready, so a record that
// raises k alarms holds it until all k are out; the sustained rate is one record per cycle
// for records with at most one alarm, and lower for runs of records with more. Records with
// no alarm leave nothing behind. Reset is synchronous and clears only the valid bits.
module metric_threshold_alarm_check #(
  parameter int MINUTES_PER_DAY = 1440
) (
  input logic          clk,
  input logic          rst,
  mtac_stream_if.sink   req,
  mtac_stream_if.source alarm
);
  import mtac_pkg::*;

  localparam int DIV_STEPS = OBS_W;

  // chain links: index 0 is the front end output, DIV_STEPS feeds the output stage
  logic  cv [0:DIV_STEPS];
  logic  ct [0:DIV_STEPS];
  cell_t cc [0:DIV_STEPS];

  // realignment, limit compares and numerator
  mtac_front #(
    .MINUTES_PER_DAY(MINUTES_PER_DAY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .in_data  (req.data),
    .out_valid(cv[0]),
    .out_take (ct[0]),
    .out_cell (cc[0])
  );

  // row of division cells, quotient bits leave the numerator msb first
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    mtac_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(cv[i]),
      .up_take (ct[i]),
      .up_cell (cc[i]),
      .dn_valid(cv[i+1]),
      .dn_take (ct[i+1]),
      .dn_cell (cc[i+1])
    );
  end

  // change compare and alarm sequencing
  mtac_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .up_valid (cv[DIV_STEPS]),
    .up_take  (ct[DIV_STEPS]),
    .up_cell  (cc[DIV_STEPS]),
    .out_valid(alarm.valid),
    .out_ready(alarm.ready),
    .out_data (alarm.data)
  );

endmodule

FILE: hdl/mtac_checker.sv
// port-level checks on the alarm channel, bound to the top level
// depends on mtac_pkg and metric_threshold_alarm_check_defines.svh
`timescale 1ns / 1ps
`include "metric_threshold_alarm_check_defines.svh"

module mtac_checker (
  input logic             clk,
  input logic             rst,
  input logic             alarm_valid,
  input logic             alarm_ready,
  input mtac_pkg::alarm_t alarm_data
);
  import mtac_pkg::*;

  // a stalled alarm stays put
  `MTAC_ASSERT_NXT(a_alarm_hold, alarm_valid && !alarm_ready, alarm_valid && $stable(alarm_data))

  // alarms of one record follow back to back in rising kind order
  `MTAC_ASSERT_NXT(a_kind_order, alarm_valid && alarm_ready && !alarm_data.last_alarm, alarm_valid && (alarm_data.alarm_kind > $past(alarm_data.alarm_kind)))

  // below minimum really is below the limit
  `MTAC_ASSERT_IMP(a_low_bound, alarm_valid && (alarm_data.alarm_kind == KIND_LOW), alarm_data.observed_value < OBS_W'(alarm_data.limit_value))

  // above maximum and change alarms really exceed the limit
  `MTAC_ASSERT_IMP(a_high_bound, alarm_valid && (alarm_data.alarm_kind != KIND_LOW), alarm_data.observed_value > OBS_W'(alarm_data.limit_value))

endmodule

bind metric_threshold_alarm_check mtac_checker u_mtac_checker (
  .clk        (clk),
  .rst        (rst),
  .alarm_valid(alarm.valid),
  .alarm_ready(alarm.ready),
  .alarm_data (alarm.data)
);

FILE: verif/mtac_alarm_checker.sv
// alarm checker for the metric threshold alarm check: predicts alarms from
// accepted records and compares them with the alarm channel
// depends on mtac_pkg and mtac_stream_if
`timescale 1ns / 1ps

module mtac_alarm_checker #(
  parameter int MINUTES_PER_DAY = 1440
) (
  input  logic   clk,
  input  logic   rst,
  mtac_stream_if req_mon,
  mtac_stream_if alarm_mon,
  output int     errors,
  output int     outstanding
);
  import mtac_pkg::*;

  alarm_t expected_alarms[$];

  task automatic report_mismatch(input string what);
    $display("%0t alarm mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic alarm_t alarm_item(input alarm_kind_t kind, input logic msk,
                                        input logic [VAL_W-1:0] limit,
                                        input logic [OBS_W-1:0] obs);
    alarm_t a;
    a.alarm_kind     = kind;
    a.masked         = msk;
    a.limit_value    = limit;
    a.observed_value = obs;
    a.last_alarm     = 1'b0;
    return a;
  endfunction

  // realign the stored values, then queue one alarm per check that fires
  function automatic void predict_alarms(input req_t r);
    logic [VAL_W-1:0] last_v;
    logic [VAL_W-1:0] prior_v;
    logic [VAL_W-1:0] diff;
    logic [VAL_W:0]   stale_at;
    logic [OBS_W-1:0] pct;
    logic             msk;
    int               rec_m;
    int               cur_m;
    int               n;
    alarm_t           hits[3];
    last_v   = r.last_value;
    prior_v  = r.prior_value;
    stale_at = {1'b0, r.report_seconds} + (VAL_W+1)'(MINUTES_PER_DAY * 60);
    rec_m    = int'(r.record_minute);
    cur_m    = int'(r.current_minute);
    n        = 0;
    if (r.is_cumulative) begin
      if (prior_v >= last_v) last_v = prior_v;
    end else if ({1'b0, r.now_seconds} >= stale_at) begin
      last_v  = '0;
      prior_v = '0;
    end else if (cur_m != rec_m) begin
      if ((rec_m + 1) % MINUTES_PER_DAY == cur_m) begin
        prior_v = last_v;
        last_v  = r.current_value;
      end else if ((rec_m + 2) % MINUTES_PER_DAY == cur_m) begin
        prior_v = r.current_value;
        last_v  = '0;
      end else begin
        last_v  = '0;
        prior_v = '0;
      end
    end
    msk = r.rule_flags[FLAG_MASK] | r.rule_flags[FLAG_DENY_ALL] |
          (r.rule_flags[FLAG_DENY_EXC] & r.rule_flags[FLAG_EXCEPT]);
    if (r.rule_flags[FLAG_MIN_EN] && last_v < r.limit_low) begin
      hits[n] = alarm_item(KIND_LOW, msk, r.limit_low, OBS_W'(last_v));
      n++;
    end
    if (r.rule_flags[FLAG_MAX_EN] && last_v > r.limit_high) begin
      hits[n] = alarm_item(KIND_HIGH, msk, r.limit_high, OBS_W'(last_v));
      n++;
    end
    if (r.rule_flags[FLAG_CHG_EN] && prior_v != '0) begin
      diff = (last_v >= prior_v) ? last_v - prior_v : prior_v - last_v;
      pct  = (OBS_W'(diff) * OBS_W'(100)) / OBS_W'(prior_v);
      if (pct > OBS_W'(r.limit_change)) begin
        hits[n] = alarm_item(KIND_CHANGE, msk, VAL_W'(r.limit_change), pct);
        n++;
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) hits[i].last_alarm = 1'b1;
      // append at the tail of the queue
      expected_alarms = {expected_alarms, hits[i]};
    end
  endfunction

  always @(posedge clk) begin : watch_channels
    alarm_t got;
    alarm_t want;
    if (rst) begin
      expected_alarms.delete();
      outstanding <= 0;
    end else begin
      if (req_mon.valid && req_mon.ready) predict_alarms(req_mon.data);
      if (alarm_mon.valid && alarm_mon.ready) begin
        got = alarm_mon.data;
        if (expected_alarms.size() == 0) begin
          report_mismatch($sformatf("unexpected alarm kind %0d observed %0d",
                                    got.alarm_kind, got.observed_value));
        end else begin
          want = expected_alarms.pop_front();
          if (got.alarm_kind !== want.alarm_kind)
            report_mismatch($sformatf("alarm_kind got %0d want %0d",
                                      got.alarm_kind, want.alarm_kind));
          if (got.masked !== want.masked)
            report_mismatch($sformatf("masked got %0b want %0b", got.masked, want.masked));
          if (got.limit_value !== want.limit_value)
            report_mismatch($sformatf("limit_value got %0d want %0d",
                                      got.limit_value, want.limit_value));
          if (got.observed_value !== want.observed_value)
            report_mismatch($sformatf("observed_value got %0d want %0d",
                                      got.observed_value, want.observed_value));
          if (got.last_alarm !== want.last_alarm)
            report_mismatch($sformatf("last_alarm got %0b want %0b",
                                      got.last_alarm, want.last_alarm));
        end
      end
      outstanding <= expected_alarms.size();
    end
  end

endmodule

FILE: verif/tb_metric_threshold_alarm_check.sv
// testbench top for the metric threshold alarm check: drives records,
// stalls the alarm side and gives the verdict
// depends on mtac_pkg, mtac_stream_if, mtac_alarm_checker and the block
`timescale 1ns / 1ps

module tb_metric_threshold_alarm_check;
  import mtac_pkg::*;

  localparam int          MINUTES_PER_DAY = 1440;
  localparam int unsigned STALE_SECONDS   = MINUTES_PER_DAY * 60;
  localparam int          RANDOM_ITEMS    = 220;
  // last stretch of random items runs with no idling on either side
  localparam int          CALM_ITEMS      = 40;
  // long enough to cover any alarm still in flight
  localparam int          DRAIN_CYCLES    = 80;

  // single rule flag bits
  localparam logic [FLAG_W-1:0] F_MIN  = FLAG_W'(1 << FLAG_MIN_EN);
  localparam logic [FLAG_W-1:0] F_MAX  = FLAG_W'(1 << FLAG_MAX_EN);
  localparam logic [FLAG_W-1:0] F_CHG  = FLAG_W'(1 << FLAG_CHG_EN);
  localparam logic [FLAG_W-1:0] F_MASK = FLAG_W'(1 << FLAG_MASK);
  localparam logic [FLAG_W-1:0] F_EXC  = FLAG_W'(1 << FLAG_EXCEPT);
  localparam logic [FLAG_W-1:0] F_DALL = FLAG_W'(1 << FLAG_DENY_ALL);
  localparam logic [FLAG_W-1:0] F_DEXC = FLAG_W'(1 << FLAG_DENY_EXC);

  logic clk;
  logic rst;
  logic calm;
  int   errors;
  int   outstanding;

  mtac_stream_if #(.T(req_t))   req ();
  mtac_stream_if #(.T(alarm_t)) alarm ();

  metric_threshold_alarm_check #(.MINUTES_PER_DAY(MINUTES_PER_DAY)) dut (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .alarm (alarm)
  );

  // predictor and comparison live in the checker; it only watches the channels
  mtac_alarm_checker #(.MINUTES_PER_DAY(MINUTES_PER_DAY)) u_alarm_checker (
    .clk         (clk),
    .rst         (rst),
    .req_mon     (req),
    .alarm_mon   (alarm),
    .errors      (errors),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin : watchdog
    #2ms;
    $display("end of test: mismatches");
    $finish;
  end

  // build one record, fields in port order
  function automatic req_t record_of(
    input logic [VAL_W-1:0]  now_s,    input logic [MIN_W-1:0] cur_min,
    input logic [VAL_W-1:0]  rep_s,    input logic [MIN_W-1:0] rec_min,
    input logic [VAL_W-1:0]  cur_v,    input logic [VAL_W-1:0] last_v,
    input logic [VAL_W-1:0]  prior_v,  input logic             cumul,
    input logic [FLAG_W-1:0] flags,    input logic [VAL_W-1:0] lo,
    input logic [VAL_W-1:0]  hi,       input logic [CHG_W-1:0] chg);
    req_t r;
    r.now_seconds    = now_s;
    r.current_minute = cur_min;
    r.report_seconds = rep_s;
    r.record_minute  = rec_min;
    r.current_value  = cur_v;
    r.last_value     = last_v;
    r.prior_value    = prior_v;
    r.is_cumulative  = cumul;
    r.rule_flags     = flags;
    r.limit_low      = lo;
    r.limit_high     = hi;
    r.limit_change   = chg;
    return r;
  endfunction

  // values cluster at zero, near the top and in a small band so checks fire often
  function automatic logic [VAL_W-1:0] rand_val();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 3);
      2:       return 32'hFFFF_FFFF - $urandom_range(0, 3);
      default: return $urandom_range(0, 1000);
    endcase
  endfunction

  function automatic req_t rand_record();
    req_t        r;
    int unsigned now_s;
    int unsigned base;
    int          cur;
    int          rec;
    // noise: every field independent and full width
    if ($urandom_range(0, 6) == 0) begin
      r = record_of($urandom, MIN_W'($urandom), $urandom, MIN_W'($urandom),
                    $urandom, $urandom, $urandom, 1'($urandom), FLAG_W'($urandom),
                    $urandom, $urandom, CHG_W'($urandom));
      return r;
    end
    now_s = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 100000) : $urandom;
    cur   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                        : $urandom_range(0, MINUTES_PER_DAY - 1);
    rec   = cur;
    r.is_cumulative = 1'b0;
    r.current_value = rand_val();
    r.last_value    = rand_val();
    r.prior_value   = rand_val();
    // fresh by default: report less than a day old, or any time if now is early
    r.report_seconds = (now_s >= STALE_SECONDS) ? now_s - $urandom_range(0, STALE_SECONDS - 1)
                                                : $urandom;
    case ($urandom_range(0, 5))
      0: begin
        // running total ignores age and minute
        r.is_cumulative  = 1'b1;
        r.report_seconds = $urandom;
        rec = $urandom_range(0, 2047);
      end
      1: begin
        // at least a day old
        if (now_s < STALE_SECONDS) now_s = now_s + STALE_SECONDS;
        base = now_s - STALE_SECONDS;
        r.report_seconds = $urandom_range(0, 1) ? base : $urandom_range(0, base);
      end
      2: rec = cur;
      3: begin
        rec = (cur + MINUTES_PER_DAY - 1) % MINUTES_PER_DAY;
        // same slot seen through an out-of-range record minute
        if (cur < MINUTES_PER_DAY && cur + MINUTES_PER_DAY - 1 <= 2047 &&
            $urandom_range(0, 3) == 0)
          rec = cur + MINUTES_PER_DAY - 1;
      end
      4: rec = (cur + MINUTES_PER_DAY - 2) % MINUTES_PER_DAY;
      default: rec = $urandom_range(0, 2047);
    endcase
    r.now_seconds    = now_s;
    r.current_minute = MIN_W'(cur);
    r.record_minute  = MIN_W'(rec);
    r.rule_flags     = FLAG_W'($urandom);
    if ($urandom_range(0, 1)) r.rule_flags[2:0] = 3'b111;
    // thresholds either free or just around the stored value
    r.limit_low  = $urandom_range(0, 1) ? rand_val() : r.last_value + $urandom_range(0, 2) - 1;
    r.limit_high = $urandom_range(0, 1) ? rand_val() : r.last_value + $urandom_range(0, 2) - 1;
    case ($urandom_range(0, 3))
      0:       r.limit_change = CHG_W'($urandom);
      1:       r.limit_change = $urandom_range(0, 1) ? '0 : '1;
      default: r.limit_change = CHG_W'($urandom_range(0, 600));
    endcase
    return r;
  endfunction

  // offer one record and hold it until the block takes it
  task automatic send_record(input req_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= r;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // alarm side: random stall bursts between runs of ready
  initial begin : alarm_ready_drive
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left   = 0;
    alarm.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst || calm) begin
        alarm.ready <= 1'b1;
      end else if (stall_left > 0) begin
        alarm.ready <= 1'b0;
        stall_left--;
      end else if (run_left > 0) begin
        alarm.ready <= 1'b1;
        run_left--;
      end else if ($urandom_range(0, 2) == 0) begin
        alarm.ready <= 1'b0;
        stall_left = $urandom_range(0, 14);
      end else begin
        alarm.ready <= 1'b1;
        run_left = $urandom_range(0, 40);
      end
    end
  end

  initial begin : stimulus
    rst       <= 1'b1;
    calm      <= 1'b0;
    req.valid <= 1'b0;
    req.data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed part; arguments: now, cur min, report, rec min, cur, last, prior,
    // cumulative, flags, low, high, change
    // everything zero, and everything at its top value
    send_record(record_of(0, 0, 0, 0, 0, 0, 0, 1'b0, '0, 0, 0, 0));
    send_record(record_of('1, '1, '1, '1, '1, '1, '1, 1'b1, '1, '1, '1, '1));
    // below minimum, above maximum at the top of the range
    send_record(record_of(1000000, 100, 1000000, 100, 0, 5, 7, 1'b0, F_MIN, 6, 0, 0));
    send_record(record_of(1000000, 100, 1000000, 100, 0, '1, 7, 1'b0, F_MAX, 0,
                          32'hFFFF_FFFE, 0));
    // percent change just over and exactly at the limit
    send_record(record_of(1000000, 100, 1000000, 100, 0, 150, 100, 1'b0, F_CHG, 0, 0, 49));
    send_record(record_of(1000000, 100, 1000000, 100, 0, 150, 100, 1'b0, F_CHG, 0, 0, 50));
    // all three checks fire on one record
    send_record(record_of(1000000, 100, 1000000, 100, 0, 5, 1, 1'b0, F_MIN | F_MAX | F_CHG,
                          '1, 0, 0));
    // largest possible percent, and a full drop to zero
    send_record(record_of(1000000, 100, 1000000, 100, 0, '1, 1, 1'b0, F_CHG, 0, 0, '1));
    send_record(record_of(1000000, 100, 1000000, 100, 0, 0, '1, 1'b0, F_CHG, 0, 0, 99));
    // zero prior skips the change check
    send_record(record_of(1000000, 100, 1000000, 100, 0, 10, 0, 1'b0, F_MIN | F_CHG,
                          11, 0, 0));
    // running total takes the larger value even when stale and out of slot
    send_record(record_of(1000000 + STALE_SECONDS + 5, 300, 1000000, 100, 0, 10, 20, 1'b1,
                          F_MAX, 0, 15, 0));
    // stale exactly at one day, and one second short of it
    send_record(record_of(1000000 + STALE_SECONDS, 100, 1000000, 100, 0, 9, 9, 1'b0,
                          F_MIN | F_CHG, 1, 0, 0));
    send_record(record_of(1000000 + STALE_SECONDS - 1, 100, 1000000, 100, 0, 3, 9, 1'b0,
                          F_MIN, 4, 0, 0));
    // report time near the top: the day bound must not wrap
    send_record(record_of('1, 100, '1, 100, 0, 7, 9, 1'b0, F_MIN, 8, 0, 0));
    // one minute behind, and across midnight
    send_record(record_of(1000000, 6, 1000000, 5, 40, 20, 9, 1'b0, F_MIN | F_CHG, 50, 0, 0));
    send_record(record_of(1000000, 0, 1000000, 1439, 40, 20, 9, 1'b0, F_MIN | F_CHG,
                          50, 0, 0));
    // two minutes behind across midnight
    send_record(record_of(1000000, 1, 1000000, 1439, 30, 20, 9, 1'b0, F_CHG, 0, 0, 99));
    // any other gap clears both values
    send_record(record_of(1000000, 200, 1000000, 100, 30, 20, 9, 1'b0, F_MIN, 1, 0, 0));
    // minute fields beyond the day length: the record minute is taken modulo the day, the current one as given
    send_record(record_of(1000000, 608, 1000000, 2047, 77, 20, 9, 1'b0, F_MIN, 78, 0, 0));
    send_record(record_of(1000000, 1500, 1000000, 1500, 0, 9, 9, 1'b0, F_MIN, 10, 0, 0));
    send_record(record_of(1000000, 1441, 1000000, 1440, 30, 20, 9, 1'b0, F_MIN, 1, 0, 0));
    // mask sources: rule mask, deny all, deny exceptions on an exception rule,
    // and the two exception bits alone, which do not mask
    send_record(record_of(1000000, 100, 1000000, 100, 0, 5, 5, 1'b0, F_MIN | F_MASK, 6, 0, 0));
    send_record(record_of(1000000, 100, 1000000, 100, 0, 5, 5, 1'b0, F_MIN | F_DALL, 6, 0, 0));
    send_record(record_of(1000000, 100, 1000000, 100, 0, 5, 5, 1'b0, F_MIN | F_DEXC | F_EXC,
                          6, 0, 0));
    send_record(record_of(1000000, 100, 1000000, 100, 0, 5, 5, 1'b0, F_MIN | F_DEXC, 6, 0, 0));
    send_record(record_of(1000000, 100, 1000000, 100, 0, 5, 5, 1'b0, F_MIN | F_EXC, 6, 0, 0));

    // random part, mostly well-formed realignment cases with some noise
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
      send_record(rand_record());
    end
    req.valid <= 1'b0;

    // let the last record's alarms show up in the count, then drain
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
